@@ design/ampq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the array min priority queue.
// No dependencies.
package ampq_pkg;

  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

@@ design/ampq_ram.sv @@
`timescale 1ns / 1ps
// Entry store: one write port, one read port with registered read data.
// No package dependencies.
module ampq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 24,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ampq_seq.sv @@
`timescale 1ns / 1ps
// Command sequencer: a minimum scan through one priority comparator and a
// shift-down pass over the entry RAM. Depends on ampq_pkg.
module ampq_seq #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned VALUE_BITS    = 16,
  parameter int unsigned PRIORITY_BITS = 8,
  localparam int unsigned AW           = $clog2(DEPTH),
  localparam int unsigned CW           = $clog2(DEPTH + 1),
  localparam int unsigned EW           = VALUE_BITS + PRIORITY_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  ampq_pkg::cmd_e           cmd_i,
  input  logic [VALUE_BITS-1:0]    value_i,
  input  logic [PRIORITY_BITS-1:0] prio_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  logic                     taken_i,
  output ampq_pkg::status_e        status_o,
  output logic [VALUE_BITS-1:0]    value_o,
  output logic [PRIORITY_BITS-1:0] prio_o,
  output logic [CW-1:0]            count_o,
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic [EW-1:0]            mem_wdata_o,
  output logic [AW-1:0]            mem_raddr_o,
  input  logic [EW-1:0]            mem_rdata_i
);
  import ampq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_SHIFT,
    S_SHIFT_LAST,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            cnt_q;
  logic [CW-1:0]            idx_q;
  logic                     rv_q;
  logic [AW-1:0]            ridx_q;
  logic [AW-1:0]            best_idx_q;
  logic [VALUE_BITS-1:0]    best_val_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;
  status_e                  status_q;
  logic [VALUE_BITS-1:0]    res_val_q;
  logic [PRIORITY_BITS-1:0] res_prio_q;
  logic                     we_q;
  logic [AW-1:0]            waddr_q;
  logic [EW-1:0]            wdata_q;

  // Shared comparator: strict less-than keeps the earliest entry on ties.
  logic [VALUE_BITS-1:0]    rd_val;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                     better;
  logic [AW-1:0]            nbest_idx;
  logic [VALUE_BITS-1:0]    nbest_val;
  logic [PRIORITY_BITS-1:0] nbest_prio;
  logic [CW-1:0]            shift_start;
  logic [CW-1:0]            last_idx;

  assign rd_val      = mem_rdata_i[EW-1:PRIORITY_BITS];
  assign rd_prio     = mem_rdata_i[PRIORITY_BITS-1:0];
  assign better      = rv_q && ((ridx_q == '0) || (rd_prio < best_prio_q));
  assign nbest_idx   = better ? ridx_q  : best_idx_q;
  assign nbest_val   = better ? rd_val  : best_val_q;
  assign nbest_prio  = better ? rd_prio : best_prio_q;
  assign shift_start = CW'(nbest_idx) + CW'(1);
  assign last_idx    = cnt_q - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      ridx_q      <= '0;
      best_idx_q  <= '0;
      best_val_q  <= '0;
      best_prio_q <= '0;
      status_q    <= STATUS_OK;
      res_val_q   <= '0;
      res_prio_q  <= '0;
      we_q        <= 1'b0;
      waddr_q     <= '0;
      wdata_q     <= '0;
    end else begin
      we_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            res_val_q  <= '0;
            res_prio_q <= '0;
            if (cmd_i == CMD_ENQ) begin
              if (cnt_q == CW'(DEPTH)) begin
                status_q <= STATUS_FULL;
              end else begin
                we_q     <= 1'b1;
                waddr_q  <= cnt_q[AW-1:0];
                wdata_q  <= {value_i, prio_i};
                cnt_q    <= cnt_q + CW'(1);
                status_q <= STATUS_OK;
              end
              state_q <= S_DONE;
            end else if (cnt_q == '0) begin
              status_q <= STATUS_EMPTY;
              state_q  <= S_DONE;
            end else begin
              idx_q   <= '0;
              rv_q    <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          best_idx_q  <= nbest_idx;
          best_val_q  <= nbest_val;
          best_prio_q <= nbest_prio;
          rv_q        <= 1'b1;
          ridx_q      <= idx_q[AW-1:0];
          idx_q       <= idx_q + CW'(1);
          if (idx_q == last_idx) begin
            state_q <= S_SCAN_LAST;
          end
        end
        S_SCAN_LAST: begin
          best_idx_q  <= nbest_idx;
          best_val_q  <= nbest_val;
          best_prio_q <= nbest_prio;
          rv_q        <= 1'b0;
          idx_q       <= shift_start;
          if (shift_start == cnt_q) begin
            // minimum was the last entry: nothing to move
            cnt_q      <= last_idx;
            status_q   <= STATUS_OK;
            res_val_q  <= nbest_val;
            res_prio_q <= nbest_prio;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          rv_q   <= 1'b1;
          ridx_q <= idx_q[AW-1:0];
          idx_q  <= idx_q + CW'(1);
          if (rv_q) begin
            we_q    <= 1'b1;
            waddr_q <= ridx_q - AW'(1);
            wdata_q <= mem_rdata_i;
          end
          if (idx_q == last_idx) begin
            state_q <= S_SHIFT_LAST;
          end
        end
        S_SHIFT_LAST: begin
          rv_q       <= 1'b0;
          we_q       <= 1'b1;
          waddr_q    <= ridx_q - AW'(1);
          wdata_q    <= mem_rdata_i;
          cnt_q      <= last_idx;
          status_q   <= STATUS_OK;
          res_val_q  <= best_val_q;
          res_prio_q <= best_prio_q;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (taken_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign status_o    = status_q;
  assign value_o     = res_val_q;
  assign prio_o      = res_prio_q;
  assign count_o     = cnt_q;
  assign mem_we_o    = we_q;
  assign mem_waddr_o = waddr_q;
  assign mem_wdata_o = wdata_q;
  assign mem_raddr_o = idx_q[AW-1:0];

endmodule

@@ design/array_min_priority_queue_core.sv @@
`timescale 1ns / 1ps
// Unsorted-array minimum priority queue, top level.
// Depends on ampq_pkg, ampq_ram and ampq_seq.
//
// Entries sit in insertion order in a single RAM with one read and one write
// port. Each accepted item gives exactly one result item. Enqueue appends
// the pair at address count (status full and no change at capacity).
// Dequeue runs two passes: a scan through one priority comparator that
// reads entries 0..n-1 one per cycle and keeps the smallest priority,
// earliest entry on ties, then a shift that reads entries b+1..n-1 and
// writes each one address lower (b being the removed entry; none when b
// is the last entry). Both passes read through the registered RAM port.
// in_stall_o is high while a command is in progress; the result
// register lets a new item in while the previous result waits on
// out_stall_i. Stored values and priorities come out of reset undefined;
// only entries below the count are ever used. out_value_o and
// out_priority_o are zero except for a successful dequeue; occupancy_o is
// the count after the command.
module array_min_priority_queue_core #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned VALUE_BITS    = 16,
  parameter int unsigned PRIORITY_BITS = 8,
  localparam int unsigned CW           = $clog2(DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [VALUE_BITS-1:0]              item_value_i,
  input  logic [PRIORITY_BITS-1:0]           item_priority_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ampq_pkg::STATUS_BITS-1:0]   status_o,
  output logic [VALUE_BITS-1:0]              out_value_o,
  output logic [PRIORITY_BITS-1:0]           out_priority_o,
  output logic [CW-1:0]                      occupancy_o
);
  import ampq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = VALUE_BITS + PRIORITY_BITS;

  logic                     busy;
  logic                     done;
  logic                     taken;
  logic                     start;
  status_e                  seq_status;
  logic [VALUE_BITS-1:0]    seq_val;
  logic [PRIORITY_BITS-1:0] seq_prio;
  logic [CW-1:0]            seq_count;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [EW-1:0]            mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [EW-1:0]            mem_rdata;

  // result register
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [VALUE_BITS-1:0]    out_val_q;
  logic [PRIORITY_BITS-1:0] out_prio_q;
  logic [CW-1:0]            out_occ_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  // a finished result moves on once the output slot is empty or draining
  assign taken      = done && (!out_valid_q || !out_stall_i);

  ampq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ampq_seq #(
    .DEPTH         (DEPTH),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_e'(cmd_i)),
    .value_i     (item_value_i),
    .prio_i      (item_priority_i),
    .busy_o      (busy),
    .done_o      (done),
    .taken_i     (taken),
    .status_o    (seq_status),
    .value_o     (seq_val),
    .prio_o      (seq_prio),
    .count_o     (seq_count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_val_q    <= '0;
      out_prio_q   <= '0;
      out_occ_q    <= '0;
    end else if (taken) begin
      out_valid_q  <= 1'b1;
      out_status_q <= seq_status;
      out_val_q    <= seq_val;
      out_prio_q   <= seq_prio;
      out_occ_q    <= seq_count;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_value_o    = out_val_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = out_occ_q;

endmodule

@@ verif/ampq_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for array_min_priority_queue_core: watches both channels and predicts every result item.
// Depends on ampq_pkg.
module ampq_checker #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned VALUE_BITS    = 16,
  parameter int unsigned PRIORITY_BITS = 8,
  localparam int unsigned CW           = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     cmd_i,
  input  logic [VALUE_BITS-1:0]    item_value_i,
  input  logic [PRIORITY_BITS-1:0] item_priority_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [1:0]               status_i,
  input  logic [VALUE_BITS-1:0]    out_value_i,
  input  logic [PRIORITY_BITS-1:0] out_priority_i,
  input  logic [CW-1:0]            occupancy_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  import ampq_pkg::*;

  typedef struct packed {
    status_e                  status;
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
    logic [CW-1:0]            occupancy;
  } queue_result_t;

  logic [VALUE_BITS-1:0]    slot_value [DEPTH];
  logic [PRIORITY_BITS-1:0] slot_prio  [DEPTH];
  int unsigned              slot_count;
  queue_result_t            expected_results [$];
  int unsigned              mismatches;

  // Mirror of the queue: update the shadow array and queue up the result item.
  task automatic apply_command(input cmd_e cmd, input logic [VALUE_BITS-1:0] val,
                               input logic [PRIORITY_BITS-1:0] prio);
    queue_result_t res;
    int unsigned   best;
    res        = '0;
    res.status = STATUS_OK;
    if (cmd == CMD_ENQ) begin
      if (slot_count >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        slot_value[slot_count] = val;
        slot_prio[slot_count]  = prio;
        slot_count++;
      end
    end else if (slot_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      best = 0;
      for (int unsigned k = 1; k < slot_count; k++) begin
        if (slot_prio[k] < slot_prio[best]) best = k;
      end
      res.value = slot_value[best];
      res.prio  = slot_prio[best];
      for (int unsigned k = best; k + 1 < slot_count; k++) begin
        slot_value[k] = slot_value[k + 1];
        slot_prio[k]  = slot_prio[k + 1];
      end
      slot_count--;
    end
    res.occupancy = CW'(slot_count);
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      slot_count = 0;
      mismatches = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results first: a result never belongs to the item taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with nothing expected: status %0d value %h prio %h occ %0d",
                     $realtime, status_i, out_value_i, out_priority_i, occupancy_i);
        end else begin
          want = expected_results.pop_front();
          if (want.status != status_i || want.value != out_value_i ||
              want.prio != out_priority_i || want.occupancy != occupancy_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: expected status %0d value %h prio %h occ %0d,",
                        " got status %0d value %h prio %h occ %0d"}, $realtime,
                       want.status, want.value, want.prio, want.occupancy,
                       status_i, out_value_i, out_priority_i, occupancy_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        apply_command(cmd_e'(cmd_i), item_value_i, item_priority_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ verif/array_min_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for array_min_priority_queue_core: clock, reset, stimulus, verdict.
// Depends on ampq_pkg, ampq_checker and the block under test.
module array_min_priority_queue_core_tb;
  import ampq_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned VALUE_BITS    = 16;
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int unsigned CW            = $clog2(DEPTH + 1);
  // Slowest item: a full-queue dequeue plus sender gap and receiver stall.
  // Many times that before the run is called hung.
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned CHUNKS        = 27;
  localparam int unsigned CHUNK_ITEMS   = 50;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic                     cmd_i           = 1'b0;
  logic [VALUE_BITS-1:0]    item_value_i    = '0;
  logic [PRIORITY_BITS-1:0] item_priority_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [1:0]               status_o;
  logic [VALUE_BITS-1:0]    out_value_o;
  logic [PRIORITY_BITS-1:0] out_priority_o;
  logic [CW-1:0]            occupancy_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  // Sender runs back to back while this is set.
  bit          in_burst    = 1'b0;

  always #5 clk_i = ~clk_i;

  array_min_priority_queue_core #(
    .DEPTH        (DEPTH),
    .VALUE_BITS   (VALUE_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  ampq_checker #(
    .DEPTH        (DEPTH),
    .VALUE_BITS   (VALUE_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .out_value_i    (out_value_o),
    .out_priority_i (out_priority_o),
    .occupancy_i    (occupancy_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: any item moving on either channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one command after a random gap and hold it until taken.
  // With no gap valid simply stays high into the next item.
  task automatic send_item(input cmd_e cmd, input logic [VALUE_BITS-1:0] val,
                           input logic [PRIORITY_BITS-1:0] prio);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    item_value_i    <= val;
    item_priority_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Result side: a random stall before each result item, with a
  // stall-free stretch of 16 results out of every 64.
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      hold = (taken % 64 < 16) ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned enq_pct;
    int unsigned prio_mode;
    cmd_e        cmd;
    logic [VALUE_BITS-1:0]    val;
    logic [PRIORITY_BITS-1:0] prio;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty dequeue, field extremes, a tie on the largest priority value
    // (earliest must win), drain to empty again.
    send_item(CMD_DEQ, '1, '1);
    send_item(CMD_ENQ, '0, '0);
    send_item(CMD_ENQ, '1, '1);
    send_item(CMD_ENQ, VALUE_BITS'(16'h1234), '1);
    send_item(CMD_DEQ, '0, '0);
    send_item(CMD_DEQ, '0, '0);
    send_item(CMD_DEQ, '0, '0);
    send_item(CMD_DEQ, '0, '0);
    // Fill to capacity with repeating priorities so ties and a mid-array
    // minimum are present, then one enqueue against a full queue.
    for (int unsigned i = 0; i < DEPTH; i++)
      send_item(CMD_ENQ, VALUE_BITS'(i * 32'h0F0F + 1), PRIORITY_BITS'((i * 7) % 5 + 100));
    send_item(CMD_ENQ, '1, '0);

    // Random: chunks biased toward filling, churning or draining, with
    // priorities either spread out or squeezed into a few values for ties.
    for (int unsigned chunk = 0; chunk < CHUNKS; chunk++) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 15;
        1:       enq_pct = 50;
        default: enq_pct = 85;
      endcase
      prio_mode = $urandom_range(0, 2);
      in_burst  = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < CHUNK_ITEMS; i++) begin
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        val = VALUE_BITS'($urandom);
        case (prio_mode)
          0:       prio = PRIORITY_BITS'($urandom_range(0, 3));
          1:       prio = PRIORITY_BITS'(255 - $urandom_range(0, 3));
          default: prio = PRIORITY_BITS'($urandom);
        endcase
        send_item(cmd, val, prio);
      end
    end
    in_valid_i <= 1'b0;

    // The checker's count is registered and trails the last accept.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
